/* rtl/core/xks_pkg.sv */
// shared types, constants and helpers for the xor keystream cipher
`default_nettype none

package xks_pkg;

    localparam int KEY_BYTES_DEF     = 32;
    localparam int DERIVE_ROUNDS_DEF = 1000;
    localparam int QUEUE_DEPTH_DEF   = 4;
    localparam int SALT_BYTES        = 16;
    localparam int PASSWORD_BYTES    = 16;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;

    localparam logic [63:0] CHECKSUM_SEED = 64'h5381;
    localparam logic [7:0]  KEY_MULT      = 8'd37;
    localparam logic [7:0]  POS_OFFSET    = 8'd13;

    typedef enum logic [2:0] {
        REG_PW_LO,
        REG_PW_HI,
        REG_PW_LEN,
        REG_SALT_LO,
        REG_SALT_HI,
        REG_MODE,
        REG_UNLOCKED,
        REG_EXPECTED
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_CONT,
        KIND_START,
        KIND_LOCKED
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        kind_t      kind;
    } item_t;

    typedef struct packed {
        logic [63:0] pw_lo;
        logic [63:0] pw_hi;
        logic [4:0]  pw_len;
        logic [63:0] salt_lo;
        logic [63:0] salt_hi;
        logic        mode;
        logic        unlocked;
        logic [63:0] expected;
    } cfg_t;

    // byte j of a 16-byte value split over two 64-bit words
    function automatic logic [7:0] byte_sel(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [3:0] j);
        logic [63:0] w;
        w = j[3] ? hi : lo;
        return w[{j[2:0], 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/xks_regs.sv */
// apb configuration registers
`default_nettype none

module xks_regs (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [xks_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire  [xks_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [xks_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    output xks_pkg::cfg_t                      cfg
);
    import xks_pkg::*;

    reg_idx_t    idx;
    logic        wr_en;
    logic [63:0] pw_lo_reg;
    logic [63:0] pw_hi_reg;
    logic [4:0]  pw_len_reg;
    logic [63:0] salt_lo_reg;
    logic [63:0] salt_hi_reg;
    logic        mode_reg;
    logic        unlocked_reg;
    logic [63:0] expected_reg;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_lo_reg    <= '0;
            pw_hi_reg    <= '0;
            pw_len_reg   <= 5'd1;
            salt_lo_reg  <= '0;
            salt_hi_reg  <= '0;
            mode_reg     <= 1'b0;
            unlocked_reg <= 1'b0;
            expected_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_PW_LO:    pw_lo_reg    <= pwdata;
                REG_PW_HI:    pw_hi_reg    <= pwdata;
                REG_PW_LEN:   pw_len_reg   <= pwdata[4:0];
                REG_SALT_LO:  salt_lo_reg  <= pwdata;
                REG_SALT_HI:  salt_hi_reg  <= pwdata;
                REG_MODE:     mode_reg     <= pwdata[0];
                REG_UNLOCKED: unlocked_reg <= pwdata[0];
                REG_EXPECTED: expected_reg <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PW_LO:    prdata = pw_lo_reg;
            REG_PW_HI:    prdata = pw_hi_reg;
            REG_PW_LEN:   prdata = {59'd0, pw_len_reg};
            REG_SALT_LO:  prdata = salt_lo_reg;
            REG_SALT_HI:  prdata = salt_hi_reg;
            REG_MODE:     prdata = {63'd0, mode_reg};
            REG_UNLOCKED: prdata = {63'd0, unlocked_reg};
            REG_EXPECTED: prdata = expected_reg;
            default:      prdata = '0;
        endcase
    end

    assign cfg.pw_lo    = pw_lo_reg;
    assign cfg.pw_hi    = pw_hi_reg;
    assign cfg.pw_len   = pw_len_reg;
    assign cfg.salt_lo  = salt_lo_reg;
    assign cfg.salt_hi  = salt_hi_reg;
    assign cfg.mode     = mode_reg;
    assign cfg.unlocked = unlocked_reg;
    assign cfg.expected = expected_reg;

endmodule

`default_nettype wire

/* rtl/core/xks_front.sv */
// input side: accepts beats and tags each as locked, message start or continuation
`default_nettype none

module xks_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [7:0]           s_tdata,   // data_byte
    input  wire                  s_tlast,   // last_byte
    input  wire                  unlocked,
    input  wire                  full,
    output logic                 push,
    output xks_pkg::item_t       push_item
);
    import xks_pkg::*;

    logic in_msg_reg;
    logic in_msg_next;

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    always_comb
    begin
        push_item.data = s_tdata;
        push_item.last = s_tlast;
        if (!unlocked)
            push_item.kind = KIND_LOCKED;
        else if (!in_msg_reg)
            push_item.kind = KIND_START;
        else
            push_item.kind = KIND_CONT;

        in_msg_next = in_msg_reg;
        if (push)
        begin
            // a locked last beat abandons the message too
            if (s_tlast)
                in_msg_next = 1'b0;
            else if (unlocked)
                in_msg_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_msg_reg <= 1'b0;
        else
            in_msg_reg <= in_msg_next;
    end

endmodule

`default_nettype wire

/* rtl/core/xks_fifo.sv */
// small queue between the front and the back
`default_nettype none

module xks_fifo #(
    parameter int DEPTH = xks_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  xks_pkg::item_t       push_item,
    output logic                 full,
    input  wire                  pop,
    output xks_pkg::item_t       head,
    output logic                 empty
);
    import xks_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/xks_back.sv */
// back side: key derivation, keystream xor, checksum and output register
`default_nettype none

module xks_back #(
    parameter int KEY_BYTES     = xks_pkg::KEY_BYTES_DEF,
    parameter int DERIVE_ROUNDS = xks_pkg::DERIVE_ROUNDS_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  xks_pkg::cfg_t                      cfg,
    input  wire                                empty,
    input  xks_pkg::item_t                     head,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [xks_pkg::OUT_DATA_W-1:0]     m_tdata,   // data_out, running_checksum
    output logic                               m_tlast,   // last_out
    output logic [xks_pkg::OUT_USER_W-1:0]     m_tuser,   // integrity_ok, locked_error
    output logic                               deriving
);
    import xks_pkg::*;

    localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int RND_W  = (DERIVE_ROUNDS > 1) ? $clog2(DERIVE_ROUNDS) : 1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FILL,
        ST_ROUND
    } state_t;

    state_t              state_reg;
    logic [KIDX_W-1:0]   kidx_reg;
    logic [KIDX_W-1:0]   fill_reg;
    logic [3:0]          pw_idx_reg;
    logic [3:0]          salt_idx_reg;
    logic [RND_W-1:0]    round_reg;
    logic                derived_reg;
    logic [7:0]          pos_reg;
    logic [63:0]         sum_reg;
    logic                out_valid_reg;
    logic [7:0]          data_out_reg;
    logic                last_out_reg;
    logic [63:0]         sum_out_reg;
    logic                ok_reg;
    logic                err_reg;

    logic [7:0]          key_reg  [KEY_BYTES];
    logic [7:0]          mask_reg [KEY_BYTES];
    logic [7:0]          lane_next [KEY_BYTES];

    logic                start_derive;
    logic                take;
    logic [7:0]          ks;
    logic [7:0]          res;
    logic [7:0]          plain;
    logic [63:0]         sum_next;
    logic                ok_next;
    logic [4:0]          plen_m1;
    logic [7:0]          pw_byte;
    logic [7:0]          salt_byte;
    logic [7:0]          r8;

    assign start_derive = (state_reg == ST_RUN) && !empty && (head.kind == KIND_START)
                          && !derived_reg;
    assign take = (state_reg == ST_RUN) && !empty && (!out_valid_reg || m_tready)
                  && !start_derive;
    assign pop      = take;
    assign deriving = (state_reg != ST_RUN);

    // keystream byte: key ^ (pos*7 + 13)
    assign ks       = key_reg[kidx_reg] ^ (({pos_reg[4:0], 3'b000} - pos_reg) + POS_OFFSET);
    assign res      = head.data ^ ks;
    assign plain    = cfg.mode ? res : head.data;
    assign sum_next = {sum_reg[58:0], 5'b00000} + sum_reg + {56'd0, plain};
    assign ok_next  = head.last && cfg.mode && (sum_next == cfg.expected);

    always_comb
    begin
        if (cfg.pw_len == 5'd0)
            plen_m1 = 5'd0;
        else if (cfg.pw_len > 5'(PASSWORD_BYTES))
            plen_m1 = 5'(PASSWORD_BYTES - 1);
        else
            plen_m1 = cfg.pw_len - 5'd1;
    end

    assign pw_byte   = byte_sel(cfg.pw_lo, cfg.pw_hi, pw_idx_reg);
    assign salt_byte = byte_sel(cfg.salt_lo, cfg.salt_hi, salt_idx_reg);
    assign r8        = 8'(round_reg);

    // one derivation round for every key lane at once
    always_comb
    begin
        for (int i = 0; i < KEY_BYTES; i++)
            lane_next[i] = 8'((key_reg[i] ^ mask_reg[i]) * KEY_MULT) + r8 + 8'(i);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (state_reg == ST_FILL && fill_reg == KIDX_W'(i))
            begin
                key_reg[i]  <= 8'd0;
                mask_reg[i] <= pw_byte ^ salt_byte;
            end
            else if (state_reg == ST_ROUND)
                key_reg[i] <= lane_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            kidx_reg      <= '0;
            fill_reg      <= '0;
            pw_idx_reg    <= '0;
            salt_idx_reg  <= '0;
            round_reg     <= '0;
            derived_reg   <= 1'b0;
            pos_reg       <= '0;
            sum_reg       <= CHECKSUM_SEED;
            out_valid_reg <= 1'b0;
            data_out_reg  <= '0;
            last_out_reg  <= 1'b0;
            sum_out_reg   <= '0;
            ok_reg        <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (take)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_RUN:
                begin
                    if (start_derive)
                    begin
                        state_reg    <= ST_FILL;
                        fill_reg     <= '0;
                        pw_idx_reg   <= '0;
                        salt_idx_reg <= '0;
                    end
                    else if (take)
                    begin
                        derived_reg  <= 1'b0;
                        last_out_reg <= head.last;
                        if (head.kind == KIND_LOCKED)
                        begin
                            data_out_reg <= 8'd0;
                            sum_out_reg  <= '0;
                            ok_reg       <= 1'b0;
                            err_reg      <= 1'b1;
                        end
                        else
                        begin
                            data_out_reg <= res;
                            sum_out_reg  <= sum_next;
                            ok_reg       <= ok_next;
                            err_reg      <= 1'b0;
                        end
                        if (head.last)
                        begin
                            pos_reg  <= '0;
                            kidx_reg <= '0;
                            sum_reg  <= CHECKSUM_SEED;
                        end
                        else if (head.kind != KIND_LOCKED)
                        begin
                            pos_reg  <= pos_reg + 8'd1;
                            kidx_reg <= (kidx_reg == KIDX_W'(KEY_BYTES - 1)) ?
                                        '0 : kidx_reg + 1'b1;
                            sum_reg  <= sum_next;
                        end
                    end
                end
                ST_FILL:
                begin
                    pw_idx_reg   <= ({1'b0, pw_idx_reg} == plen_m1) ? '0 : pw_idx_reg + 4'd1;
                    salt_idx_reg <= (salt_idx_reg == 4'(SALT_BYTES - 1)) ?
                                    '0 : salt_idx_reg + 4'd1;
                    if (fill_reg == KIDX_W'(KEY_BYTES - 1))
                    begin
                        fill_reg  <= '0;
                        round_reg <= '0;
                        state_reg <= ST_ROUND;
                    end
                    else
                        fill_reg <= fill_reg + 1'b1;
                end
                ST_ROUND:
                begin
                    if (round_reg == RND_W'(DERIVE_ROUNDS - 1))
                    begin
                        round_reg   <= '0;
                        derived_reg <= 1'b1;
                        state_reg   <= ST_RUN;
                    end
                    else
                        round_reg <= round_reg + 1'b1;
                end
                default:
                    state_reg <= ST_RUN;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {sum_out_reg, data_out_reg};
    assign m_tlast  = last_out_reg;
    assign m_tuser  = {err_reg, ok_reg};

endmodule

`default_nettype wire

/* rtl/core/xor_keystream_shard_cipher.sv */
// top level of the xor keystream cipher with a hash*33 + byte checksum
//
// s_* stream carries message bytes in (tlast marks the final byte), m_* stream
// carries one result beat per input beat: tdata = {running_checksum, data_out},
// tuser = {locked_error, integrity_ok}, tlast = last_out.
// the apb port holds password, salt, mode, unlock and expected checksum
// (64-bit registers, register i at byte address 8*i); write it only while idle.
// the first unlocked byte of a message triggers key derivation: the masks of the
// key lanes are loaded one at a time (ST_FILL), then DERIVE_ROUNDS rounds of the
// lane update run (ST_ROUND), all key lanes stepping together. after that one
// byte per cycle flows while bytes are queued and m_tready is high; the checksum
// add sets the per-byte path; a beat passes the queue, then the output register.
// a short queue sits between input and processing, so input keeps being taken
// during derivation or while m_tready is low until the queue fills; a waiting
// result holds in the output register.
// reset clears the queue, the message state and the checksum (seed 0x5381);
// the key lanes hold no reset value and are rebuilt at each message start.
`default_nettype none

module xor_keystream_shard_cipher #(
    parameter int KEY_BYTES     = xks_pkg::KEY_BYTES_DEF,
    parameter int DERIVE_ROUNDS = xks_pkg::DERIVE_ROUNDS_DEF,
    parameter int QUEUE_DEPTH   = xks_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [7:0]                         s_tdata,   // data_byte
    input  wire                                s_tlast,   // last_byte
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [xks_pkg::OUT_DATA_W-1:0]     m_tdata,   // data_out, running_checksum
    output logic                               m_tlast,   // last_out
    output logic [xks_pkg::OUT_USER_W-1:0]     m_tuser,   // integrity_ok, locked_error
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [xks_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire  [xks_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [xks_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import xks_pkg::*;

    cfg_t  cfg;
    item_t push_item;
    item_t head;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    logic  deriving;

    xks_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    xks_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .unlocked  (cfg.unlocked),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    xks_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    xks_back #(
        .KEY_BYTES     (KEY_BYTES),
        .DERIVE_ROUNDS (DERIVE_ROUNDS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .deriving (deriving)
    );

    // a rejected beat never also reports a checksum match
    a_err_excl_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("locked beat flagged integrity_ok");

    a_locked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == '0))
        else $error("locked beat carries nonzero data");

    a_ok_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("integrity_ok on a non-final beat");

    // no result can be produced while the key is being rebuilt
    a_no_out_derive: assert property (@(posedge clk) disable iff (!rst_n)
        deriving |=> !$rose(m_tvalid))
        else $error("result emitted during key derivation");

endmodule

`default_nettype wire
